/* rtl/core/tioa_pkg.sv */
package tioa_pkg;

   localparam int MAX_DIMS        = 4;
   localparam int INDEX_WIDTH     = 32;
   localparam int DIM_WIDTH       = 16;
   localparam int CSR_WIDTH       = 64;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int COUNT_WIDTH     = 3;

   // quotient bits resolved per pipeline stage
   localparam int STEP_BITS     = 4;
   localparam int DIV_STAGES    = (INDEX_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_BITS      = DIV_STAGES * STEP_BITS;
   localparam int OFF_STAGES    = (DIM_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int OFF_BITS      = OFF_STAGES * STEP_BITS;
   localparam int WORD_WIDTH    = (DIV_BITS > OFF_BITS) ? DIV_BITS : OFF_BITS;
   localparam int DECODE_STAGES = MAX_DIMS * DIV_STAGES;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DIM_COUNT,
      CSR_DIM_SIZES,
      CSR_DIM_OFFSETS,
      CSR_CYCLIC_MODE
   } csr_index_type;

   localparam logic [COUNT_WIDTH-1:0] RESET_DIM_COUNT   = COUNT_WIDTH'(1);
   localparam logic [CSR_WIDTH-1:0]   RESET_DIM_SIZES   = 64'h0001_0001_0001_0001;
   localparam logic [CSR_WIDTH-1:0]   RESET_DIM_OFFSETS = '0;
   localparam logic                   RESET_CYCLIC_MODE = 1'b1;

   typedef logic [DIM_WIDTH-1:0] dim_type;
   typedef dim_type [MAX_DIMS-1:0] dim_vec_type;

   // partial remainder plus dividend bits shifting out and quotient bits shifting in
   typedef struct packed {
      logic [DIM_WIDTH-1:0]  rem;
      logic [WORD_WIDTH-1:0] word;
   } div_state_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] index;
      logic                   in_range;
   } result_type;

   // STEP_BITS steps of restoring division, divisor never zero
   function automatic div_state_type div_step(div_state_type st, dim_type divisor);
      logic [DIM_WIDTH:0] part;
      div_state_type      r;
      r = st;
      for (int b = 0; b < STEP_BITS; b++) begin
         part   = {r.rem, r.word[WORD_WIDTH-1]};
         r.word = {r.word[WORD_WIDTH-2:0], 1'b0};
         if (part >= {1'b0, divisor}) begin
            part      = part - {1'b0, divisor};
            r.word[0] = 1'b1;
         end
         r.rem = part[DIM_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/tioa_decode.sv */
module tioa_decode
   import tioa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [INDEX_WIDTH-1:0] in_index,
   input  dim_vec_type            sizes,
   output logic                   out_valid,
   output dim_vec_type            out_coord
);

   logic [DECODE_STAGES-1:0] valid_ff;
   logic [DECODE_STAGES-1:0] valid_in;
   div_state_type            state_ff [DECODE_STAGES];
   div_state_type            state_in [DECODE_STAGES];
   dim_vec_type              coord_ff [DECODE_STAGES];
   dim_vec_type              coord_in [DECODE_STAGES];

   logic [DIV_BITS-1:0] in_word;

   assign in_word = DIV_BITS'(in_index);

   for (genvar t = 0; t < DECODE_STAGES; t++) begin : g_stage
      localparam int J    = t / DIV_STAGES;
      localparam int STEP = t % DIV_STAGES;
      localparam int K    = MAX_DIMS - 1 - J;

      if (t == 0) begin : g_first
         always_comb begin
            div_state_type start;
            start.rem   = '0;
            start.word  = WORD_WIDTH'(in_word) << (WORD_WIDTH - DIV_BITS);
            valid_in[t] = in_valid;
            coord_in[t] = '0;
            state_in[t] = div_step(start, sizes[K]);
         end
      end else if (STEP == 0) begin : g_dim
         // new dimension: keep the finished remainder, restart on the quotient
         always_comb begin
            div_state_type start;
            dim_vec_type   cin;
            start       = state_ff[t-1];
            cin         = coord_ff[t-1];
            cin[K+1]    = state_ff[t-1].rem;
            start.rem   = '0;
            start.word  = WORD_WIDTH'(state_ff[t-1].word[DIV_BITS-1:0])
                          << (WORD_WIDTH - DIV_BITS);
            valid_in[t] = valid_ff[t-1];
            coord_in[t] = cin;
            state_in[t] = div_step(start, sizes[K]);
         end
      end else begin : g_next
         always_comb begin
            valid_in[t] = valid_ff[t-1];
            coord_in[t] = coord_ff[t-1];
            state_in[t] = div_step(state_ff[t-1], sizes[K]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int t = 0; t < DECODE_STAGES; t++) begin
            state_ff[t] <= state_in[t];
            coord_ff[t] <= coord_in[t];
         end
      end
   end

   always_comb begin
      out_valid    = valid_ff[DECODE_STAGES-1];
      out_coord    = coord_ff[DECODE_STAGES-1];
      out_coord[0] = state_ff[DECODE_STAGES-1].rem;
   end

endmodule

/* rtl/core/tensor_index_offset_add.sv */
// stages from an accepted request to rsp_valid: 1 input register, 32 decode stages
//   at 4 quotient bits each, 1 offset stage, 4 multiply stages, the output register
// throughput: one transaction per cycle unless the skid is full; divider fully pipelined
// a two-entry output (register plus skid) keeps accepting while one result waits
// reset: synchronous, active high; clears valids and loads the default registers
module tensor_index_offset_add
   import tioa_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [INDEX_WIDTH-1:0]     req_flat_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [INDEX_WIDTH-1:0]     rsp_result_index,
   output logic                       rsp_in_range,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata
);

   // configuration registers
   logic [COUNT_WIDTH-1:0] dim_count_ff;
   logic [CSR_WIDTH-1:0]   dim_sizes_ff;
   logic [CSR_WIDTH-1:0]   dim_offsets_ff;
   logic                   cyclic_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff   <= RESET_DIM_COUNT;
         dim_sizes_ff   <= RESET_DIM_SIZES;
         dim_offsets_ff <= RESET_DIM_OFFSETS;
         cyclic_mode_ff <= RESET_CYCLIC_MODE;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DIM_COUNT:   dim_count_ff   <= csr_wdata[COUNT_WIDTH-1:0];
            CSR_DIM_SIZES:   dim_sizes_ff   <= csr_wdata;
            CSR_DIM_OFFSETS: dim_offsets_ff <= csr_wdata;
            CSR_CYCLIC_MODE: cyclic_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // packed field of dimension d, dimension zero most significant
   function automatic dim_type field_of(logic [CSR_WIDTH-1:0] w, int d);
      int                   sh;
      logic [CSR_WIDTH-1:0] t;
      sh = (MAX_DIMS - 1 - d) * DIM_WIDTH;
      if (sh >= CSR_WIDTH) begin
         return '0;
      end
      t = w >> sh;
      return t[DIM_WIDTH-1:0];
   endfunction

   // effective per-dimension sizes and offsets; unused dimensions act as size 1, offset 0
   logic [COUNT_WIDTH:0] count_eff;
   dim_vec_type          size_eff_in;
   dim_vec_type          offset_eff_in;
   dim_vec_type          size_eff_ff;
   dim_vec_type          offset_eff_ff;

   always_comb begin
      if (dim_count_ff == '0) begin
         count_eff = (COUNT_WIDTH+1)'(1);
      end else if (int'(dim_count_ff) > MAX_DIMS) begin
         count_eff = (COUNT_WIDTH+1)'(MAX_DIMS);
      end else begin
         count_eff = {1'b0, dim_count_ff};
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         if ((COUNT_WIDTH+1)'(d) < count_eff) begin
            size_eff_in[d]   = field_of(dim_sizes_ff, d);
            offset_eff_in[d] = field_of(dim_offsets_ff, d);
            if (size_eff_in[d] == '0) begin
               size_eff_in[d] = DIM_WIDTH'(1);
            end
         end else begin
            size_eff_in[d]   = DIM_WIDTH'(1);
            offset_eff_in[d] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      size_eff_ff   <= size_eff_in;
      offset_eff_ff <= offset_eff_in;
   end

   // |offset| mod size per dimension, settles from the registers long before
   // the first transaction reaches the offset stage
   div_state_type off_state_ff [MAX_DIMS][OFF_STAGES];
   div_state_type off_state_in [MAX_DIMS][OFF_STAGES];
   dim_vec_type   off_rem;

   always_comb begin
      div_state_type start;
      dim_type       mag;
      for (int d = 0; d < MAX_DIMS; d++) begin
         mag = offset_eff_ff[d][DIM_WIDTH-1] ? (~offset_eff_ff[d] + DIM_WIDTH'(1))
                                             : offset_eff_ff[d];
         start.rem  = '0;
         start.word = WORD_WIDTH'(mag) << (WORD_WIDTH - OFF_BITS);
         off_state_in[d][0] = div_step(start, size_eff_ff[d]);
         for (int s = 1; s < OFF_STAGES; s++) begin
            off_state_in[d][s] = div_step(off_state_ff[d][s-1], size_eff_ff[d]);
         end
         off_rem[d] = off_state_ff[d][OFF_STAGES-1].rem;
      end
   end

   always_ff @(posedge clock) begin
      off_state_ff <= off_state_in;
   end

   // pipeline advance; only a full skid entry freezes it
   logic pipe_en;
   logic skid_valid_ff;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // input register
   logic                   in_valid_ff;
   logic [INDEX_WIDTH-1:0] in_flat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         in_flat_ff <= req_flat_index;
      end
   end

   // mixed-radix decode, last dimension first
   logic        dec_valid;
   dim_vec_type dec_coord;

   tioa_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (in_valid_ff),
      .in_index  (in_flat_ff),
      .sizes     (size_eff_ff),
      .out_valid (dec_valid),
      .out_coord (dec_coord)
   );

   // offset add: cyclic wrap or range check per dimension
   dim_vec_type           adj_coord_in;
   logic [MAX_DIMS-1:0]   dim_ok;
   logic                  adj_valid_ff;
   dim_vec_type           adj_coord_ff;
   logic                  adj_ok_ff;

   always_comb begin
      dim_type              adj;
      logic [DIM_WIDTH:0]   wrap_sum;
      logic [DIM_WIDTH+1:0] lin_sum;
      logic                 fits;
      for (int d = 0; d < MAX_DIMS; d++) begin
         // negative offset becomes size minus its magnitude remainder
         if (!offset_eff_ff[d][DIM_WIDTH-1]) begin
            adj = off_rem[d];
         end else if (off_rem[d] == '0) begin
            adj = '0;
         end else begin
            adj = size_eff_ff[d] - off_rem[d];
         end
         wrap_sum = {1'b0, dec_coord[d]} + {1'b0, adj};
         if (wrap_sum >= {1'b0, size_eff_ff[d]}) begin
            wrap_sum = wrap_sum - {1'b0, size_eff_ff[d]};
         end
         lin_sum = {2'b00, dec_coord[d]}
                   + {{2{offset_eff_ff[d][DIM_WIDTH-1]}}, offset_eff_ff[d]};
         fits = !lin_sum[DIM_WIDTH+1] && (lin_sum[DIM_WIDTH:0] < {1'b0, size_eff_ff[d]});
         if (cyclic_mode_ff) begin
            adj_coord_in[d] = wrap_sum[DIM_WIDTH-1:0];
            dim_ok[d]       = 1'b1;
         end else begin
            adj_coord_in[d] = lin_sum[DIM_WIDTH-1:0];
            dim_ok[d]       = fits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         adj_valid_ff <= dec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         adj_coord_ff <= adj_coord_in;
         adj_ok_ff    <= &dim_ok;
      end
   end

   // row-major recombine, one multiply-add per stage
   logic [MAX_DIMS-1:0]    mul_valid_ff;
   logic [MAX_DIMS-1:0]    mul_ok_ff;
   logic [INDEX_WIDTH-1:0] mul_acc_ff   [MAX_DIMS];
   dim_vec_type            mul_coord_ff [MAX_DIMS];
   logic [INDEX_WIDTH-1:0] mul_acc_in   [MAX_DIMS];

   for (genvar m = 0; m < MAX_DIMS; m++) begin : g_mul
      logic [INDEX_WIDTH-1:0]           prev_acc;
      dim_vec_type                      prev_coord;
      logic                             prev_valid;
      logic                             prev_ok;
      logic [INDEX_WIDTH+DIM_WIDTH-1:0] prod;

      if (m == 0) begin : g_first
         assign prev_acc   = '0;
         assign prev_coord = adj_coord_ff;
         assign prev_valid = adj_valid_ff;
         assign prev_ok    = adj_ok_ff;
      end else begin : g_next
         assign prev_acc   = mul_acc_ff[m-1];
         assign prev_coord = mul_coord_ff[m-1];
         assign prev_valid = mul_valid_ff[m-1];
         assign prev_ok    = mul_ok_ff[m-1];
      end

      assign prod          = prev_acc * size_eff_ff[m];
      assign mul_acc_in[m] = prod[INDEX_WIDTH-1:0] + INDEX_WIDTH'(prev_coord[m]);

      always_ff @(posedge clock) begin
         if (reset) begin
            mul_valid_ff[m] <= 1'b0;
         end else if (pipe_en) begin
            mul_valid_ff[m] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            mul_acc_ff[m]   <= mul_acc_in[m];
            mul_coord_ff[m] <= prev_coord;
            mul_ok_ff[m]    <= prev_ok;
         end
      end
   end

   // result formatting: out-of-range forces a zero index
   logic       last_valid;
   result_type last_result;

   assign last_valid           = mul_valid_ff[MAX_DIMS-1];
   assign last_result.in_range = mul_ok_ff[MAX_DIMS-1];
   assign last_result.index    = mul_ok_ff[MAX_DIMS-1] ? mul_acc_ff[MAX_DIMS-1] : '0;

   // output register plus skid entry
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       skid_valid_in;
   result_type rsp_data_ff;
   result_type rsp_data_in;
   result_type skid_data_ff;
   result_type skid_data_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!skid_valid_ff) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_in = last_valid;
            rsp_data_in  = last_result;
         end else if (last_valid) begin
            // result register still held: park the arriving transaction
            skid_valid_in = 1'b1;
            skid_data_in  = last_result;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_data_ff.index;
   assign rsp_in_range     = rsp_data_ff.in_range;

`ifndef SYNTH
   // skid entry only fills behind a held result
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without a result in the output register");

   // a drained skid entry is not refilled in the same cycle
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff)
      else $error("skid entry did not drain");

   // out-of-range results carry a zero index
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.in_range) |-> (rsp_data_ff.index == '0))
      else $error("out of range result with nonzero index");

   // a stalled result is replaced by the skid entry only once released
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");
`endif

endmodule

/* tb/tioa_checker.sv */
module tioa_checker
   import tioa_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [INDEX_WIDTH-1:0]     req_flat_index,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [INDEX_WIDTH-1:0]     rsp_result_index,
   input  logic                       rsp_in_range,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata,
   output int                         fail_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [COUNT_WIDTH-1:0] shadow_count;
   logic [CSR_WIDTH-1:0]   shadow_sizes;
   logic [CSR_WIDTH-1:0]   shadow_offsets;
   logic                   shadow_cyclic;
   result_type             expected_q[$];

   function automatic longint dim_size(int d);
      longint s;
      s = longint'(shadow_sizes[(MAX_DIMS-1-d)*DIM_WIDTH +: DIM_WIDTH]);
      return (s == 0) ? 1 : s;
   endfunction

   function automatic longint dim_offset(int d);
      logic signed [DIM_WIDTH-1:0] v;
      v = shadow_offsets[(MAX_DIMS-1-d)*DIM_WIDTH +: DIM_WIDTH];
      return longint'(v);
   endfunction

   function automatic result_type offset_index(logic [INDEX_WIDTH-1:0] flat_in);
      longint     coord[MAX_DIMS];
      longint     flat, sum, r, s;
      logic [63:0] acc;
      int         n;
      bit         ok;
      result_type res;
      flat = longint'(flat_in);
      n = int'(shadow_count);
      ok = 1;
      acc = 0;
      if (n == 0) n = 1;
      if (n > MAX_DIMS) n = MAX_DIMS;
      for (int d = n - 1; d >= 0; d--) begin
         s = dim_size(d);
         coord[d] = flat % s;
         flat = flat / s;
      end
      for (int d = 0; d < n; d++) begin
         s = dim_size(d);
         sum = coord[d] + dim_offset(d);
         if (shadow_cyclic) begin
            r = sum % s;
            if (r < 0) r += s;
            coord[d] = r;
         end else if (sum < 0 || sum >= s) begin
            ok = 0;
            break;
         end else begin
            coord[d] = sum;
         end
      end
      if (ok)
         for (int d = 0; d < n; d++) acc = acc * 64'(dim_size(d)) + 64'(coord[d]);
      res.index = ok ? acc[INDEX_WIDTH-1:0] : '0;
      res.in_range = ok;
      return res;
   endfunction

   always @(posedge clock) begin
      result_type exp_res;
      if (reset) begin
         shadow_count <= RESET_DIM_COUNT;
         shadow_sizes <= RESET_DIM_SIZES;
         shadow_offsets <= RESET_DIM_OFFSETS;
         shadow_cyclic <= RESET_CYCLIC_MODE;
         expected_q.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_q.insert(expected_q.size(), offset_index(req_flat_index));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result index %h in_range %b", $time,
                        rsp_result_index, rsp_in_range);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = expected_q.pop_front();
               if (exp_res.index !== rsp_result_index || exp_res.in_range !== rsp_in_range) begin
                  $display("%0t: mismatch expected index %h in_range %b, actual %h %b", $time,
                           exp_res.index, exp_res.in_range, rsp_result_index, rsp_in_range);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_q.size();
         if (csr_write_en)
            case (csr_index_type'(csr_index))
               CSR_DIM_COUNT:   shadow_count <= csr_wdata[COUNT_WIDTH-1:0];
               CSR_DIM_SIZES:   shadow_sizes <= csr_wdata;
               CSR_DIM_OFFSETS: shadow_offsets <= csr_wdata;
               CSR_CYCLIC_MODE: shadow_cyclic <= csr_wdata[0];
               default: ;
            endcase
      end
   end
endmodule

/* tb/tb_top.sv */
module tb_top
   import tioa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 38;
   localparam int CYCLE_LIMIT = 400000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [INDEX_WIDTH-1:0]     req_flat_index;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [INDEX_WIDTH-1:0]     rsp_result_index;
   logic                       rsp_in_range;
   logic                       csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0]       csr_wdata;
   int                         fail_count;
   int                         pending_count;
   int                         cycle_count;
   int                         send_idle_pct;   // sender idle percentage
   int                         recv_stall_pct;  // receiver stall percentage
   int                         hold_cycles;     // long receiver hold-off when nonzero

   tensor_index_offset_add dut (.*);
   tioa_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // timeout watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("** tensor_index_offset_add: FAILED **");
            $finish;
         end
      end
   end

   // receiver side: random stalls, plus a long hold-off on request
   initial begin
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1;
            hold_cycles <= hold_cycles - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // one register write while the block is idle
   task automatic write_csr(csr_index_type idx, logic [CSR_WIDTH-1:0] value);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 0;
   endtask

   // offer one transaction, wait until accepted
   task automatic send_index(logic [INDEX_WIDTH-1:0] flat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_flat_index <= flat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // random tensor shape: mostly small sizes, sometimes zero or full range
   function automatic logic [CSR_WIDTH-1:0] pick_sizes();
      logic [CSR_WIDTH-1:0] v;
      for (int d = 0; d < MAX_DIMS; d++)
         case ($urandom_range(5))
            0: v[d*DIM_WIDTH +: DIM_WIDTH] = '0;
            1: v[d*DIM_WIDTH +: DIM_WIDTH] = 16'($urandom);
            default: v[d*DIM_WIDTH +: DIM_WIDTH] = 16'($urandom_range(1, 12));
         endcase
      return v;
   endfunction

   function automatic logic [CSR_WIDTH-1:0] pick_offsets();
      logic [CSR_WIDTH-1:0] v;
      for (int d = 0; d < MAX_DIMS; d++)
         if ($urandom_range(3) == 0) v[d*DIM_WIDTH +: DIM_WIDTH] = 16'($urandom);
         else v[d*DIM_WIDTH +: DIM_WIDTH] = 16'($urandom_range(0, 30) - 15);
      return v;
   endfunction

   initial begin
      logic [INDEX_WIDTH-1:0] flat;
      logic [INDEX_WIDTH-1:0] extremes[6];
      reset = 1;
      req_valid = 0;
      req_flat_index = 0;
      csr_write_en = 0;
      csr_index = CSR_DIM_COUNT;
      csr_wdata = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      extremes = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA};

      // directed: reset shape, then extremes over several settings
      foreach (extremes[i]) send_index(extremes[i]);
      drain();
      for (int cfg = 0; cfg < 4; cfg++) begin
         case (cfg)
            0: begin  // four dims, big offsets, cyclic
               write_csr(CSR_DIM_COUNT, 64'd4);
               write_csr(CSR_DIM_SIZES, 64'h0003_0005_0007_000B);
               write_csr(CSR_DIM_OFFSETS, 64'h7FFF_8000_FFFF_0001);
               write_csr(CSR_CYCLIC_MODE, 64'd1);
            end
            1: begin  // non-cyclic, out of range and zero size
               write_csr(CSR_CYCLIC_MODE, 64'd0);
               write_csr(CSR_DIM_SIZES, 64'h0000_FFFF_0004_0002);
               write_csr(CSR_DIM_OFFSETS, 64'h0000_0001_FFFF_0000);
            end
            2: begin  // zero count, max sizes
               write_csr(CSR_DIM_COUNT, 64'd0);
               write_csr(CSR_DIM_SIZES, 64'hFFFF_FFFF_FFFF_FFFF);
               write_csr(CSR_DIM_OFFSETS, 64'h8000_8000_8000_8000);
               write_csr(CSR_CYCLIC_MODE, 64'd1);
            end
            3: begin  // count saturates
               write_csr(CSR_DIM_COUNT, 64'd7);
               write_csr(CSR_DIM_OFFSETS, 64'h0001_0001_0001_0001);
            end
            default: ;
         endcase
         foreach (extremes[i]) send_index(extremes[i]);
         drain();
      end

      // random phases over idling modes and settings
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            3: begin send_idle_pct = 30; recv_stall_pct = 30; end
            default: ;
         endcase
         write_csr(CSR_DIM_COUNT, CSR_WIDTH'($urandom_range(0, 7)));
         write_csr(CSR_DIM_SIZES, pick_sizes());
         write_csr(CSR_DIM_OFFSETS, pick_offsets());
         write_csr(CSR_CYCLIC_MODE, CSR_WIDTH'($urandom_range(1)));
         if (phase == 4) hold_cycles <= 200;  // receiver holds off, pipeline fills
         for (int i = 0; i < 50; i++) begin
            flat = ($urandom_range(2) == 0) ? $urandom : 32'($urandom_range(0, 2000));
            send_index(flat);
         end
         drain();
      end

      if (fail_count == 0)
         $display("** tensor_index_offset_add: PASSED **");
      else
         $display("** tensor_index_offset_add: FAILED **");
      $finish;
   end
endmodule
